// ----- rtl/compass_heading_smoother_core_defines.svh -----
// ----------------------------------------------------------------------------
// Compass heading smoother: assertion macros
// Shared concurrent assertion forms, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef COMPASS_HEADING_SMOOTHER_CORE_DEFINES_SVH
`define COMPASS_HEADING_SMOOTHER_CORE_DEFINES_SVH

// same-cycle implication
`define CHS_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CHS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/chs_pkg.sv -----
// ----------------------------------------------------------------------------
// Compass heading smoother package
// Widths, angle constants, controller command type and the CORDIC atan table.
// ----------------------------------------------------------------------------
package chs_pkg;

  localparam int WindowDefault = 3;
  localparam int CordicSteps   = 20;
  localparam int StepW         = 5;

  localparam int InW    = 12;   // magnetometer sample
  localparam int CfgW   = 15;   // declination, Q3.12
  localparam int AngW   = 15;   // output angle, Q3.12
  localparam int DegW   = 9;
  localparam int HeadW  = 16;   // ring entry, Q3.12 signed
  localparam int SumW   = 20;
  localparam int XyW    = 28;   // CORDIC x/y, sample scaled by 2^12 plus gain
  localparam int ZW     = 25;   // CORDIC angle accumulator, Q.20

  localparam int ScaleShift = 12;
  localparam int RoundShift = 8;  // Q.20 -> Q.12
  localparam int RoundBias  = 128;

  localparam int PiQ20    = 3294199;
  localparam int PiQ12    = 12868;
  localparam int TwoPiQ12 = 25736;

  localparam int RecipShift = 24;
  localparam int DegK       = 234684;
  localparam int DegKW      = 18;
  localparam int DegShift   = 24;

  typedef struct packed {
    logic             load;      // start CORDIC on the accepted sample
    logic             step;      // one vectoring iteration
    logic [StepW-1:0] idx;       // iteration index
    logic             round;     // update ring and running sum
    logic             mult;      // reciprocal product of the sum
    logic             corr;      // quotient correction, signed average
    logic             wrap;      // add declination, wrap to 0..2pi
    logic             load_out;  // degrees and output register
  } cmd_t;

  // atan(2^-i) in Q.20
  function automatic logic signed [ZW-1:0] atan_q20(input logic [StepW-1:0] idx);
    logic signed [ZW-1:0] v;
    unique case (idx)
      5'd0:    v = ZW'(823550);
      5'd1:    v = ZW'(486170);
      5'd2:    v = ZW'(256879);
      5'd3:    v = ZW'(130396);
      5'd4:    v = ZW'(65451);
      5'd5:    v = ZW'(32757);
      5'd6:    v = ZW'(16383);
      5'd7:    v = ZW'(8192);
      5'd8:    v = ZW'(4096);
      5'd9:    v = ZW'(2048);
      5'd10:   v = ZW'(1024);
      5'd11:   v = ZW'(512);
      5'd12:   v = ZW'(256);
      5'd13:   v = ZW'(128);
      5'd14:   v = ZW'(64);
      5'd15:   v = ZW'(32);
      5'd16:   v = ZW'(16);
      5'd17:   v = ZW'(8);
      5'd18:   v = ZW'(4);
      5'd19:   v = ZW'(2);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ----- rtl/chs_cordic.sv -----
// ----------------------------------------------------------------------------
// Compass heading smoother: iterative CORDIC
// Vectoring-mode atan2, one shift-add iteration per step, rounded to Q3.12.
// ----------------------------------------------------------------------------
module chs_cordic (
  input  logic                                clk_i,
  input  logic                                load_i,
  input  logic                                step_i,
  input  logic [chs_pkg::StepW-1:0]           idx_i,
  input  logic signed [chs_pkg::InW-1:0]      mag_x_i,
  input  logic signed [chs_pkg::InW-1:0]      mag_y_i,
  output logic signed [chs_pkg::HeadW-1:0]    heading_o
);

  logic signed [chs_pkg::XyW-1:0] x_q, x_d, y_q, y_d;
  logic signed [chs_pkg::ZW-1:0]  z_q, z_d;
  logic                           zero_q, zero_d;
  logic signed [chs_pkg::ZW-1:0]  zr_c;

  always_comb begin
    logic signed [chs_pkg::XyW-1:0] xs, ys, dx, dy;
    logic signed [chs_pkg::ZW-1:0]  t;
    xs = chs_pkg::XyW'(mag_x_i) <<< chs_pkg::ScaleShift;
    ys = chs_pkg::XyW'(mag_y_i) <<< chs_pkg::ScaleShift;
    dx = y_q >>> idx_i;
    dy = x_q >>> idx_i;
    t  = chs_pkg::atan_q20(idx_i);
    x_d    = x_q;
    y_d    = y_q;
    z_d    = z_q;
    zero_d = zero_q;
    if (load_i) begin
      zero_d = (mag_x_i == '0) && (mag_y_i == '0);
      if (mag_x_i < 0) begin
        // left half plane: rotate by pi first
        x_d = -xs;
        y_d = -ys;
        z_d = (mag_y_i >= 0) ? chs_pkg::ZW'(chs_pkg::PiQ20) : -chs_pkg::ZW'(chs_pkg::PiQ20);
      end else begin
        x_d = xs;
        y_d = ys;
        z_d = '0;
      end
    end else if (step_i) begin
      if (!y_q[chs_pkg::XyW-1]) begin
        x_d = x_q + dx;
        y_d = y_q - dy;
        z_d = z_q + t;
      end else begin
        x_d = x_q - dx;
        y_d = y_q + dy;
        z_d = z_q - t;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    y_q    <= y_d;
    z_q    <= z_d;
    zero_q <= zero_d;
  end

  assign zr_c = (z_q + chs_pkg::ZW'(chs_pkg::RoundBias)) >>> chs_pkg::RoundShift;

  always_comb begin
    if (zero_q) begin
      heading_o = '0;
    end else if (zr_c > chs_pkg::ZW'(chs_pkg::PiQ12)) begin
      heading_o = chs_pkg::HeadW'(chs_pkg::PiQ12);
    end else if (zr_c < -chs_pkg::ZW'(chs_pkg::PiQ12)) begin
      heading_o = -chs_pkg::HeadW'(chs_pkg::PiQ12);
    end else begin
      heading_o = chs_pkg::HeadW'(zr_c);
    end
  end

endmodule

// ----- rtl/chs_ctrl.sv -----
// ----------------------------------------------------------------------------
// Compass heading smoother: controller
// Sequences the CORDIC iterations and the averaging steps, owns output valid.
// ----------------------------------------------------------------------------
`include "compass_heading_smoother_core_defines.svh"

module chs_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output chs_pkg::cmd_t cmd_o
);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_ITER  = 7'b0000010,
    ST_ROUND = 7'b0000100,
    ST_MULT  = 7'b0001000,
    ST_CORR  = 7'b0010000,
    ST_WRAP  = 7'b0100000,
    ST_DEG   = 7'b1000000
  } state_e;

  state_e                    state_q, state_d;
  logic [chs_pkg::StepW-1:0] step_q, step_d;
  logic                      out_valid_q, out_valid_d;

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    cmd_o   = '0;
    cmd_o.idx = step_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          step_d     = '0;
          state_d    = ST_ITER;
        end
      end
      ST_ITER: begin
        cmd_o.step = 1'b1;
        if (step_q == chs_pkg::StepW'(chs_pkg::CordicSteps - 1)) begin
          state_d = ST_ROUND;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      ST_ROUND: begin
        cmd_o.round = 1'b1;
        state_d     = ST_MULT;
      end
      ST_MULT: begin
        cmd_o.mult = 1'b1;
        state_d    = ST_CORR;
      end
      ST_CORR: begin
        cmd_o.corr = 1'b1;
        state_d    = ST_WRAP;
      end
      ST_WRAP: begin
        cmd_o.wrap = 1'b1;
        state_d    = ST_DEG;
      end
      ST_DEG: begin
        // wait for the output register to free up
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_d = cmd_o.load_out | (out_valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

  `CHS_ASSERT_NEXT(a_accept_starts_iter, in_valid_i && !in_stall_o, state_q == ST_ITER && step_q == '0, "accepted beat did not start CORDIC at step 0")
  `CHS_ASSERT_NEXT(a_last_step_rounds, state_q == ST_ITER && step_q == chs_pkg::StepW'(chs_pkg::CordicSteps - 1), state_q == ST_ROUND, "CORDIC did not stop after last step")
  `CHS_ASSERT_IMPL(a_out_from_deg, $rose(out_valid_q), $past(state_q == ST_DEG), "output valid rose outside degree stage")

endmodule

// ----- rtl/chs_dp.sv -----
// ----------------------------------------------------------------------------
// Compass heading smoother: datapath
// CORDIC unit, heading ring with running sum, rounded mean, wrap and degrees.
// ----------------------------------------------------------------------------
`include "compass_heading_smoother_core_defines.svh"

module chs_dp #(
  parameter int WINDOW = chs_pkg::WindowDefault
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  chs_pkg::cmd_t                     cmd_i,
  input  logic signed [chs_pkg::InW-1:0]    mag_x_i,
  input  logic signed [chs_pkg::InW-1:0]    mag_y_i,
  input  logic                              cfg_we_i,
  input  logic signed [chs_pkg::CfgW-1:0]   cfg_data_i,
  output logic [chs_pkg::AngW-1:0]          heading_angle_o,
  output logic [chs_pkg::DegW-1:0]          heading_deg_o
);

  localparam int PosW    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int Div     = 2 * WINDOW;
  localparam int NW      = chs_pkg::SumW + 1;
  localparam int ProdW   = NW + chs_pkg::RecipShift;
  localparam int AW      = chs_pkg::HeadW + 1;
  localparam int DegPW   = chs_pkg::AngW + chs_pkg::DegKW + 1;
  localparam logic [chs_pkg::RecipShift-1:0] Recip =
    chs_pkg::RecipShift'((1 << chs_pkg::RecipShift) / Div);

  logic signed [chs_pkg::HeadW-1:0] head_c;
  logic signed [chs_pkg::HeadW-1:0] ring_q [WINDOW];
  logic [PosW-1:0]                  pos_q;
  logic signed [chs_pkg::SumW-1:0]  sum_q;
  logic signed [chs_pkg::CfgW-1:0]  decl_q;

  logic [NW-1:0]                    n_q, q0_q;
  logic                             neg_q;
  logic signed [chs_pkg::HeadW-1:0] avg_q;
  logic [chs_pkg::AngW-1:0]         angle_q;
  logic [chs_pkg::AngW-1:0]         out_angle_q;
  logic [chs_pkg::DegW-1:0]         out_deg_q;

  chs_cordic u_cordic (
    .clk_i     (clk_i),
    .load_i    (cmd_i.load),
    .step_i    (cmd_i.step),
    .idx_i     (cmd_i.idx),
    .mag_x_i   (mag_x_i),
    .mag_y_i   (mag_y_i),
    .heading_o (head_c)
  );

  // ring, running sum, declination
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < WINDOW; k++) begin
        ring_q[k] <= '0;
      end
      pos_q  <= '0;
      sum_q  <= '0;
      decl_q <= '0;
    end else begin
      if (cmd_i.round) begin
        ring_q[pos_q] <= head_c;
        sum_q <= sum_q - chs_pkg::SumW'(ring_q[pos_q]) + chs_pkg::SumW'(head_c);
        pos_q <= (pos_q == PosW'(WINDOW - 1)) ? '0 : pos_q + 1'b1;
      end
      if (cfg_we_i) begin
        decl_q <= cfg_data_i;
      end
    end
  end

  // mean with ties away from zero: (2|s| + W) / 2W via reciprocal, one fixup
  logic [chs_pkg::SumW-1:0] mag_c;
  logic [NW-1:0]            n_c;
  logic [ProdW-1:0]         prod_c;
  logic [NW-1:0]            qdiv_c, rem_c, q_c;
  logic [chs_pkg::HeadW-1:0] qt_c;

  assign mag_c  = sum_q[chs_pkg::SumW-1] ? chs_pkg::SumW'(-sum_q) : chs_pkg::SumW'(sum_q);
  assign n_c    = {mag_c, 1'b0} + NW'(WINDOW);
  assign prod_c = ProdW'(n_c) * ProdW'(Recip);
  assign qdiv_c = NW'(q0_q * NW'(Div));
  assign rem_c  = n_q - qdiv_c;
  assign q_c    = (rem_c >= NW'(Div)) ? q0_q + 1'b1 : q0_q;
  assign qt_c   = chs_pkg::HeadW'(q_c);

  // declination and wrap into 0..2pi
  logic signed [AW-1:0] a_c, t1_c, t2_c;
  localparam logic signed [AW-1:0] TwoPi = AW'(chs_pkg::TwoPiQ12);

  always_comb begin
    a_c = AW'(avg_q) + AW'(decl_q);
    if (a_c < 0) begin
      t1_c = a_c + TwoPi;
    end else if (a_c > TwoPi) begin
      t1_c = a_c - TwoPi;
    end else begin
      t1_c = a_c;
    end
    t2_c = (t1_c < 0) ? t1_c + TwoPi : t1_c;
  end

  logic [DegPW-1:0] dprod_c;
  assign dprod_c = DegPW'(angle_q) * DegPW'(chs_pkg::DegK)
                 + (DegPW'(1) << (chs_pkg::DegShift - 1));

  always_ff @(posedge clk_i) begin
    if (cmd_i.mult) begin
      n_q   <= n_c;
      q0_q  <= prod_c[chs_pkg::RecipShift +: NW];
      neg_q <= sum_q[chs_pkg::SumW-1];
    end
    if (cmd_i.corr) begin
      avg_q <= neg_q ? (~qt_c + 1'b1) : qt_c;
    end
    if (cmd_i.wrap) begin
      angle_q <= chs_pkg::AngW'(t2_c);
    end
    if (cmd_i.load_out) begin
      out_angle_q <= angle_q;
      out_deg_q   <= dprod_c[chs_pkg::DegShift +: chs_pkg::DegW];
    end
  end

  assign heading_angle_o = out_angle_q;
  assign heading_deg_o   = out_deg_q;

  `CHS_ASSERT_IMPL(a_pos_in_range, 1'b1, pos_q <= PosW'(WINDOW - 1), "ring position past window")
  `CHS_ASSERT_NEXT(a_wrap_in_range, cmd_i.wrap, angle_q <= chs_pkg::AngW'(chs_pkg::TwoPiQ12), "wrapped angle above 2pi")

endmodule

// ----- rtl/compass_heading_smoother_core.sv -----
// Sequence: from the input beat to out_valid_o the controller runs 20 iterations
//   of the shared CORDIC shift-add unit plus round, divide, fixup, wrap, degrees.
// Acceptance: in_stall_o stays high until the controller is back in idle; a held
//   result delays the final degree stage, and no new sample is taken meanwhile.
// Reset (async, active low) clears the heading ring, sum, ring position,
//   declination and controller state at once; no clearing pass.
// ----------------------------------------------------------------------------
// Compass heading smoother core
// atan2 heading of a magnetometer sample, averaged over a window, plus
// declination, wrapped to 0..2pi, as Q3.12 radians and whole degrees.
// ----------------------------------------------------------------------------
module compass_heading_smoother_core #(
  parameter int WINDOW = chs_pkg::WindowDefault
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic signed [chs_pkg::InW-1:0]  mag_x_i,
  input  logic signed [chs_pkg::InW-1:0]  mag_y_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [chs_pkg::AngW-1:0]        heading_angle_o,
  output logic [chs_pkg::DegW-1:0]        heading_deg_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic signed [chs_pkg::CfgW-1:0] cfg_data_i
);

  chs_pkg::cmd_t cmd;

  // register write is always taken
  assign cfg_ready_o = 1'b1;

  chs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  chs_dp #(
    .WINDOW (WINDOW)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .mag_x_i         (mag_x_i),
    .mag_y_i         (mag_y_i),
    .cfg_we_i        (cfg_valid_i & cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .heading_angle_o (heading_angle_o),
    .heading_deg_o   (heading_deg_o)
  );

endmodule

// ----- tb/compass_heading_smoother_core_test.sv -----
// ----------------------------------------------------------------------------
// Compass heading smoother core testbench
// Feeds magnetometer samples through the core under several declination
// settings and handshake idling patterns. Each result beat is checked
// against a CORDIC heading and window-average predictor kept in the bench.
// ----------------------------------------------------------------------------
module compass_heading_smoother_core_test;

  localparam int InW        = chs_pkg::InW;
  localparam int CfgW       = chs_pkg::CfgW;
  localparam int AngW       = chs_pkg::AngW;
  localparam int DegW       = chs_pkg::DegW;
  localparam int Window     = 3;
  localparam int Steps      = 20;
  localparam longint PiFine = 3294199;  // pi, Q.20
  localparam longint PiQ12  = 12868;
  localparam longint TwoPi  = 25736;
  localparam longint DegMul = 234684;
  localparam int StallLimit = 4000;

  typedef struct packed {
    logic signed [InW-1:0] x;
    logic signed [InW-1:0] y;
  } sample_t;

  typedef struct packed {
    logic [AngW-1:0] angle;
    logic [DegW-1:0] deg;
  } heading_t;

  logic                   clk_i       = 1'b0;
  logic                   rst_ni      = 1'b0;
  logic                   in_valid_i  = 1'b0;
  logic                   in_stall_o;
  logic signed [InW-1:0]  mag_x_i     = '0;
  logic signed [InW-1:0]  mag_y_i     = '0;
  logic                   out_valid_o;
  logic                   out_stall_i = 1'b0;
  logic [AngW-1:0]        heading_angle_o;
  logic [DegW-1:0]        heading_deg_o;
  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic signed [CfgW-1:0] cfg_data_i  = '0;

  compass_heading_smoother_core #(
    .WINDOW(Window)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .mag_x_i        (mag_x_i),
    .mag_y_i        (mag_y_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .heading_angle_o(heading_angle_o),
    .heading_deg_o  (heading_deg_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // atan(2^-i), Q.20
  longint atan_steps [0:Steps-1] = '{
    823550, 486170, 256879, 130396, 65451, 32757, 16383, 8192, 4096, 2048,
    1024, 512, 256, 128, 64, 32, 16, 8, 4, 2
  };

  // predictor state
  longint heading_hist [0:Window-1] = '{default: 0};
  int     hist_slot   = 0;
  longint heading_sum = 0;
  longint declination = 0;

  sample_t  sample_q [$];
  heading_t heading_due [$];
  sample_t  next_sample;
  heading_t want;
  int       send_idle_pct  = 0;
  int       recv_stall_pct = 0;
  int       fail_count     = 0;
  int       quiet_cycles   = 0;

  function automatic longint cordic_heading(input longint sx, input longint sy);
    longint x, y, z, dx, dy, r;
    if (sx == 0 && sy == 0) return 0;
    x = sx * 4096;
    y = sy * 4096;
    z = 0;
    if (x < 0) begin
      z = (y >= 0) ? PiFine : -PiFine;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < Steps; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x = x + dx;
        y = y - dy;
        z = z + atan_steps[i];
      end else begin
        x = x - dx;
        y = y + dy;
        z = z - atan_steps[i];
      end
    end
    r = (z + 128) >>> 8;
    if (r > PiQ12) r = PiQ12;
    if (r < -PiQ12) r = -PiQ12;
    return r;
  endfunction

  function automatic heading_t smooth_heading(input logic signed [InW-1:0] mx,
                                              input logic signed [InW-1:0] my);
    longint   h, mag, avg, ang, deg;
    heading_t res;
    h = cordic_heading(longint'(mx), longint'(my));
    heading_sum = heading_sum - heading_hist[hist_slot] + h;
    heading_hist[hist_slot] = h;
    hist_slot = (hist_slot + 1) % Window;
    // mean rounded to nearest, ties away from zero
    mag = (heading_sum < 0) ? -heading_sum : heading_sum;
    avg = (2 * mag + Window) / (2 * Window);
    if (heading_sum < 0) avg = -avg;
    ang = avg + declination;
    while (ang < 0) ang = ang + TwoPi;
    while (ang > TwoPi) ang = ang - TwoPi;
    deg = (ang * DegMul + (64'sd1 <<< 23)) >>> 24;
    res.angle = ang[AngW-1:0];
    res.deg   = deg[DegW-1:0];
    return res;
  endfunction

  // sample driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        heading_due.push_back(smooth_heading(mag_x_i, mag_y_i));
      end
      if (!in_valid_i || !in_stall_o) begin
        if (sample_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_sample = sample_q.pop_front();
          mag_x_i    <= next_sample.x;
          mag_y_i    <= next_sample.y;
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (heading_due.size() == 0) begin
          $error("result beat with nothing pending: heading_angle %0d heading_deg %0d",
                 heading_angle_o, heading_deg_o);
          fail_count++;
        end else begin
          want = heading_due.pop_front();
          if (heading_angle_o !== want.angle) begin
            $error("heading_angle: expected %0d, got %0d", want.angle, heading_angle_o);
            fail_count++;
          end
          if (heading_deg_o !== want.deg) begin
            $error("heading_deg: expected %0d, got %0d", want.deg, heading_deg_o);
            fail_count++;
          end
        end
      end
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // watchdog on beats of any channel
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= StallLimit) begin
        $display("compass_heading_smoother_core_test NOT OK");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic queue_sample(input int xv, input int yv);
    sample_t s;
    s.x = InW'(xv);
    s.y = InW'(yv);
    sample_q.push_back(s);
  endtask

  // checked on the falling edge, once the driver and monitor have settled
  task automatic drain;
    while (sample_q.size() != 0 || in_valid_i || heading_due.size() != 0)
      @(negedge clk_i);
  endtask

  task automatic write_declination(input int value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= CfgW'(value);
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    declination = longint'(cfg_data_i);
  endtask

  task automatic run_phase(input int send_pct, input int recv_pct, input int count);
    int sel, xv, yv;
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    for (int n = 0; n < count; n++) begin
      sel = $urandom_range(9);
      if (sel == 0) begin
        // tiny vectors, zero vector among them
        xv = int'($urandom_range(6)) - 3;
        yv = int'($urandom_range(6)) - 3;
      end else if (sel == 1) begin
        xv = ($urandom_range(1) == 0) ? 0 : int'($urandom_range(4095)) - 2048;
        yv = (xv == 0) ? int'($urandom_range(4095)) - 2048 : 0;
      end else if (sel == 2) begin
        // near the +-pi seam
        xv = -int'($urandom_range(2048, 500));
        yv = int'($urandom_range(40)) - 20;
      end else begin
        xv = int'($urandom_range(4095)) - 2048;
        yv = int'($urandom_range(4095)) - 2048;
      end
      queue_sample(xv, yv);
    end
    drain();
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed corners, declination at its reset value
    queue_sample(0, 0);
    queue_sample(2047, 0);
    queue_sample(-2048, 0);
    queue_sample(0, 2047);
    queue_sample(0, -2048);
    queue_sample(2047, 2047);
    queue_sample(-2048, -2048);
    queue_sample(-2048, 2047);
    queue_sample(2047, -2048);
    queue_sample(-1, 0);
    queue_sample(-5, 0);
    queue_sample(-1, -1);
    queue_sample(-1, 1);
    queue_sample(1, 1);
    queue_sample(1, -1);
    queue_sample(0, 1);
    queue_sample(0, -1);
    queue_sample(-2048, 1);
    queue_sample(-2048, -1);
    queue_sample(-2048, 1);
    queue_sample(-2048, -1);
    queue_sample(0, 0);
    queue_sample(0, 0);
    queue_sample(0, 0);
    run_phase(0, 0, 200);

    write_declination(12868);
    run_phase(88, 0, 200);
    write_declination(-12868);
    run_phase(0, 88, 200);
    // outside the nominal range, still wrapped
    write_declination(16383);
    run_phase(32, 32, 200);
    write_declination(-16384);
    run_phase(0, 0, 200);
    write_declination(int'($urandom_range(25736)) - 12868);
    run_phase(32, 32, 150);
    write_declination(0);
    run_phase(88, 88, 150);

    repeat (40) @(posedge clk_i);
    if (fail_count == 0 && heading_due.size() == 0) begin
      $display("compass_heading_smoother_core_test OK");
    end else begin
      $display("compass_heading_smoother_core_test NOT OK");
    end
    $finish;
  end

endmodule
